### hdl/lspfg_pkg.sv
`timescale 1ns / 1ps
// Package with the constants and helper functions of the LED strip pattern generator.
package lspfg_pkg;
  localparam int unsigned StripPixels = 64;
  localparam int unsigned FadeSpan    = 4;
  localparam int unsigned CenterIndex = 32;
  localparam int unsigned MaxValue    = 15;
  localparam int unsigned IdxW        = 6;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegHue  = 2'd1;
  localparam logic [1:0] RegSat  = 2'd2;

  localparam logic [3:0] ModeRainbow   = 4'd0;
  localparam logic [3:0] ModePulseHold = 4'd1;
  localparam logic [3:0] ModeBreathe   = 4'd2;
  localparam logic [3:0] ModeSingle    = 4'd3;
  localparam logic [3:0] ModeDouble    = 4'd4;
  localparam logic [3:0] ModeBroken    = 4'd5;
  localparam logic [3:0] ModePinwheel  = 4'd6;
  localparam logic [3:0] ModeQuad      = 4'd7;
  localparam logic [3:0] ModeFocPulse  = 4'd8;
  localparam logic [3:0] ModeFocBreath = 4'd9;

  // Circular distance between two pixel positions on the ring.
  function automatic logic [5:0] ring_dist(input logic [5:0] a, input logic [5:0] b);
    logic [5:0] d1;
    logic [5:0] d2;
    d1 = a - b;
    d2 = b - a;
    return (d1 < d2) ? d1 : d2;
  endfunction

  // Linear fade from top at distance zero to nothing at span; narrow table logic.
  function automatic logic [3:0] fade_val(input logic [5:0] x, input logic [4:0] span,
                                          input logic [3:0] top);
    logic [9:0] num;
    logic [9:0] q;
    num = 10'(x) * 10'(top);
    q   = 10'd0;
    case (span)
      5'd1:    q = num;
      5'd2:    q = num >> 1;
      5'd3:    q = 10'((num * 10'd11) >> 5)
                   + 10'(((num - 10'((num*10'd11)>>5)*10'd3) >= 10'd3) ? 1 : 0);
      5'd4:    q = num >> 2;
      default: q = 10'd0;
    endcase
    return (6'(span) > x) ? 4'(10'(top) - q) : 4'd0;
  endfunction

  // Breathing value: s>>4 inside inner, tapering to span, else zero.
  function automatic logic [3:0] breathe_val(input logic [5:0] x, input logic [7:0] s,
                                             input logic [4:0] inner, input logic [4:0] span);
    logic [13:0] p;
    logic [13:0] q;
    p = 14'(s) * 14'(x);
    if (span == 5'd8) q = p >> 3;
    else q = 14'((28'(p) * 28'd4370) >> 16);
    if (x < 6'(inner)) return s[7:4];
    if (x < 6'(span))  return 4'((14'(s) - q) >> 4);
    return 4'd0;
  endfunction
endpackage

### hdl/led_strip_pattern_frame_generator.sv
`timescale 1ns / 1ps
// Top level of the LED strip pattern frame generator.
//
// An item on the slave stream is a frame tick carrying the focus position in
// s_axis_tdata[5:0]. The block then runs a small sequencer in two passes over
// the strip. The render pass makes one store write per cycle through a
// shared pixel unit and fills the frame store in every decoded pattern;
// the double, broken, pinwheel and quadrant patterns spend those writes on
// copies of each source pixel, mirrored in part for the quadrant pattern.
// An undecoded mode renders nothing and leaves the pass at once. The emit
// pass reads the store one pixel per cycle, while the receiver takes them,
// through a read register into an output register and sends 64 items on the
// master stream, tlast on the last one. s_axis_tready is high only while the
// block is idle, so a new tick waits until both passes are done. When the
// receiver drops m_axis_tready the emit pass holds: the item in the output
// register stays and the pending read waits in the read register; no item
// is lost. Reset clears the registers to mode 0, hue 0, saturation 15,
// both counters zero and all direction flags rising. The frame store has no
// reset; every decoded mode writes it fully before reading, unknown modes
// re-emit the old frame.
// Configuration writes through cfg_we_i, cfg_idx_i and cfg_data_i belong in
// cycles where the block is idle; a write to the mode register clears both
// counters.
module led_strip_pattern_frame_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] focus_position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] pixel_index, [21:6] pixel_word
  output logic        m_axis_tlast,   // frame_last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRender = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;
  localparam int unsigned StripPixelsC = lspfg_pkg::StripPixels;

  logic [1:0] state_q, state_d;
  logic [3:0] mode_q;
  logic [7:0] hue_q;
  logic [3:0] sat_q;
  logic [7:0] step_q;
  logic [2:0] pulse_q;
  logic [2:0] dir_q;
  logic [5:0] head_q;
  logic [5:0] i_q;     // source pixel of the render pass
  logic [2:0] k_q;     // copy number for copied and mirrored writes
  logic [6:0] rd_q;    // next read address of the emit pass
  logic       rd_pend_q;
  logic [5:0] rd_idx_q;
  logic [15:0] store [StripPixelsC];

  logic [3:0] val;
  logic [5:0] waddr;
  logic       wen;
  logic       last_write;
  logic [2:0] k_last;
  logic [7:0] hue_w;
  logic       out_free;

  // Shared pixel unit: value and address of the current render write.
  always_comb begin
    val = 4'd0; waddr = i_q; hue_w = hue_q; k_last = 3'd0;
    wen = 1'b1;
    case (mode_q)
      lspfg_pkg::ModeRainbow: begin
        hue_w = 8'(((14'(i_q) + 14'(step_q)) * 14'd255) >> 6);
        val = 4'(lspfg_pkg::MaxValue);
      end
      lspfg_pkg::ModePulseHold: val = step_q[7:4];
      lspfg_pkg::ModeBreathe:
        val = lspfg_pkg::breathe_val(lspfg_pkg::ring_dist(i_q, 6'(lspfg_pkg::CenterIndex)),
                                     step_q, 5'd10, 5'd15);
      lspfg_pkg::ModeSingle:
        val = lspfg_pkg::fade_val(lspfg_pkg::ring_dist(i_q, step_q[5:0]), 5'd4, 4'd15);
      lspfg_pkg::ModeDouble: begin
        // i walks 0..15 then 48..63; copy 1 adds or subtracts half the strip.
        if (i_q < 6'd16) val = lspfg_pkg::fade_val(i_q, 5'd4, 4'd15);
        else val = lspfg_pkg::fade_val(6'd0 - i_q, 5'd4, 4'd15);
        waddr = i_q + step_q[5:0] + (k_q[0] ? 6'd32 : 6'd0);
        k_last = 3'd1;
      end
      lspfg_pkg::ModeBroken: begin
        val = lspfg_pkg::fade_val(lspfg_pkg::ring_dist(i_q, step_q[5:0]), 5'd4, 4'd15);
        waddr = {k_q[0], i_q[4:0]};
        k_last = 3'd1;
      end
      lspfg_pkg::ModePinwheel: begin
        val = lspfg_pkg::fade_val(lspfg_pkg::ring_dist(i_q, step_q[5:0]), 5'd2, 4'd15);
        waddr = {k_q, i_q[2:0]};
        k_last = 3'd7;
      end
      lspfg_pkg::ModeQuad: begin
        val = lspfg_pkg::fade_val(lspfg_pkg::ring_dist(i_q, step_q[5:0]), 5'd4, 4'd15);
        case (k_q[1:0])
          2'd0:    waddr = i_q;
          2'd1:    waddr = 6'd31 - i_q;
          2'd2:    waddr = i_q + 6'd32;
          default: waddr = 6'd63 - i_q;
        endcase
        k_last = 3'd3;
      end
      lspfg_pkg::ModeFocPulse:
        val = lspfg_pkg::fade_val(lspfg_pkg::ring_dist(i_q, head_q),
                                  5'(3'd4 - {1'b0, step_q[1:0]}), 4'd15);
      lspfg_pkg::ModeFocBreath:
        val = lspfg_pkg::breathe_val(lspfg_pkg::ring_dist(i_q, head_q), step_q, 5'd8, 5'd8);
      default: wen = 1'b0;
    endcase
    case (mode_q)
      lspfg_pkg::ModeDouble:   last_write = (i_q == 6'd63) && (k_q == k_last);
      lspfg_pkg::ModeBroken:   last_write = (i_q == 6'd31) && (k_q == k_last);
      lspfg_pkg::ModePinwheel: last_write = (i_q == 6'd7) && (k_q == k_last);
      lspfg_pkg::ModeQuad:     last_write = (i_q == 6'd15) && (k_q == k_last);
      default:                 last_write = (i_q == 6'd63);
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (s_axis_tvalid) state_d = StRender;
      StRender: if (last_write || !wen) state_d = StEmit;
      StEmit:   if (rd_q == 7'd64 && !rd_pend_q && out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Frame store: one write port for rendering, one registered read port.
  logic [15:0] rd_data_q;
  logic rd_en;
  assign rd_en = (state_q == StEmit) && rd_q < 7'd64 && (!rd_pend_q || out_free);
  always_ff @(posedge clk_i) begin
    if (state_q == StRender && wen)
      store[waddr] <= {hue_w, sat_q, val};
    if (rd_en) rd_data_q <= store[rd_q[5:0]];
  end

  // Counter update at the end of rendering, shared step arithmetic.
  logic [7:0] step_n;
  logic [2:0] pulse_n;
  logic [2:0] dir_n;
  logic       rise;
  always_comb begin
    step_n = step_q; pulse_n = pulse_q; dir_n = dir_q; rise = 1'b0;
    case (mode_q)
      lspfg_pkg::ModePulseHold: begin
        rise = dir_q[0];
        if (step_q == 8'd255 || step_q == 8'd0) begin
          rise = (step_q == 8'd0);
          if (pulse_q < 3'd4) pulse_n = pulse_q + 3'd1;
        end
        dir_n[0] = rise;
        if (pulse_n < 3'd4) step_n = rise ? step_q + 8'd15 : step_q - 8'd15;
      end
      lspfg_pkg::ModeBreathe: begin
        rise = dir_q[1];
        if (step_q >= 8'd241) rise = 1'b0;
        else if (step_q <= 8'd60) rise = 1'b1;
        dir_n[1] = rise;
        step_n = rise ? step_q + 8'd15 : step_q - 8'd15;
      end
      lspfg_pkg::ModeFocBreath: begin
        rise = dir_q[2];
        if (step_q >= 8'd216) rise = 1'b0;
        else if (step_q <= 8'd80) rise = 1'b1;
        dir_n[2] = rise;
        step_n = rise ? step_q + 8'd40 : step_q - 8'd40;
      end
      lspfg_pkg::ModePinwheel: step_n = {4'd0, step_q[3:0] + 4'd1};
      lspfg_pkg::ModeQuad:     step_n = {3'd0, step_q[4:0] + 5'd1};
      lspfg_pkg::ModeRainbow, lspfg_pkg::ModeSingle, lspfg_pkg::ModeDouble,
      lspfg_pkg::ModeBroken, lspfg_pkg::ModeFocPulse:
        step_n = {2'd0, step_q[5:0] + 6'd1};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= 4'd0; hue_q <= 8'd0; sat_q <= 4'd15;
      step_q <= 8'd0; pulse_q <= 3'd0; dir_q <= 3'b111;
      head_q <= 6'd0; i_q <= 6'd0; k_q <= 3'd0; rd_q <= 7'd0;
      rd_pend_q <= 1'b0; rd_idx_q <= 6'd0; m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && s_axis_tvalid) begin
        head_q <= s_axis_tdata[5:0];
        i_q <= (mode_q == lspfg_pkg::ModeDouble) ? 6'd0 : 6'd0;
        k_q <= 3'd0; rd_q <= 7'd0;
      end
      if (state_q == StRender) begin
        if (last_write || !wen) begin
          step_q <= step_n; pulse_q <= pulse_n; dir_q <= dir_n;
        end else if (k_q == k_last) begin
          k_q <= 3'd0;
          i_q <= (mode_q == lspfg_pkg::ModeDouble && i_q == 6'd15) ? 6'd48 : i_q + 6'd1;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
      if (out_free) m_axis_tvalid <= rd_pend_q;
      if (rd_en) begin
        rd_pend_q <= 1'b1; rd_idx_q <= rd_q[5:0]; rd_q <= rd_q + 7'd1;
      end else if (out_free) rd_pend_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lspfg_pkg::RegMode: begin
            mode_q <= cfg_data_i[3:0]; step_q <= 8'd0; pulse_q <= 3'd0;
          end
          lspfg_pkg::RegHue: hue_q <= cfg_data_i;
          lspfg_pkg::RegSat: sat_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // Output register, loaded whenever it is free and a read is pending.
  always_ff @(posedge clk_i) begin
    if (out_free && rd_pend_q) begin
      m_axis_tdata <= {2'b00, rd_data_q, rd_idx_q};
      m_axis_tlast <= (rd_idx_q == 6'd63);
    end
  end
endmodule

### hdl/lspfg_checker.sv
`timescale 1ns / 1ps
// Port checker for the LED strip pattern frame generator, with its bind.
module lspfg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");
  ap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:0] == 6'd63)))
    else $error("tlast does not match last index");
  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while emitting");
  ap_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
    |-> m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)
    else $error("pixel index skipped");
  ap_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after a frame tick");
endmodule

bind led_strip_pattern_frame_generator lspfg_checker u_lspfg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));
